FILE: hw/rtl/rvc_pkg.sv
// rvc_pkg: shared constants and types for the range value count unit.
// Used by rvc_cell, rvc_ctrl, range_value_count_unit and the testbench; depends on nothing.
package rvc_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int VALUE_BITS   = 32;
	localparam int NUM_CELLS    = 8;
	localparam int BANK_DEPTH   = MAX_ELEMENTS / NUM_CELLS;
	localparam int BANK_AW      = $clog2(BANK_DEPTH);
	localparam int CELL_W       = $clog2(NUM_CELLS);

	localparam int LOAD_W       = 32;
	localparam int BOUND_W      = 32;
	localparam int IDX_W        = 11;
	localparam int CNT_W        = 12;
	localparam int FILL_W       = $clog2(MAX_ELEMENTS + 1);
	localparam int RNG_W        = (FILL_W > IDX_W) ? FILL_W : IDX_W;
	localparam int CMP_W        = (VALUE_BITS > BOUND_W) ? VALUE_BITS : BOUND_W;

	localparam int DRAIN_LEN    = NUM_CELLS + 1;
	localparam int DRAIN_W      = $clog2(DRAIN_LEN + 1);

	typedef enum logic [1:0] {
		KIND_CLEAR   = 2'd0,
		KIND_APPEND  = 2'd1,
		KIND_AT_MOST = 2'd2,
		KIND_BAND    = 2'd3
	} kind_t;

	// query broadcast from the sequencer to every cell
	typedef struct packed {
		logic                       sweep;
		logic [BANK_AW-1:0]         addr;
		logic                       clr;
		logic                       incl;
		logic                       band;
		logic [RNG_W-1:0]           lo;
		logic [RNG_W-1:0]           hi;
		logic signed [BOUND_W-1:0]  bnd_a;
		logic signed [BOUND_W-1:0]  bnd_b;
	} ctl_t;

	// append write, steered to one cell's bank
	typedef struct packed {
		logic                         we;
		logic [CELL_W-1:0]            bank;
		logic [BANK_AW-1:0]           addr;
		logic signed [VALUE_BITS-1:0] data;
	} wr_t;

endpackage

FILE: hw/rtl/range_value_count_unit.sv
// range_value_count_unit: top level. A sequencer and a chain of NUM_CELLS
// counting cells, each holding one bank of the stored values.
// Depends on rvc_pkg, rvc_cell, rvc_ctrl.
//
//  channel   | handshake      | word
//  ----------+----------------+----------------------------------------------
//  command   | start / busy   | kind, load_value, left_index, right_index,
//            |                | bound_low, bound_high
//  result    | done (strobe)  | match_count
//
// Clear and append do not occupy the sequencer: busy stays low, the next word may follow.
// A query runs from accept to done as the bank address sweep over each cell's
// single read port, then one hop per cell along the sum chain. busy drops in
// the cycle that done is high.
// Reset is asynchronous and empties the array; no clearing pass is needed.
// The receiver cannot stall: done is high for exactly one cycle per query.
module range_value_count_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           kind,
	input  logic signed [rvc_pkg::LOAD_W-1:0]    load_value,
	input  logic [rvc_pkg::IDX_W-1:0]            left_index,
	input  logic [rvc_pkg::IDX_W-1:0]            right_index,
	input  logic signed [rvc_pkg::BOUND_W-1:0]   bound_low,
	input  logic signed [rvc_pkg::BOUND_W-1:0]   bound_high,
	output logic                                 done,
	output logic signed [rvc_pkg::CNT_W-1:0]     match_count
);

	rvc_pkg::ctl_t                    ctl;
	rvc_pkg::wr_t                     wr;
	logic signed [rvc_pkg::CNT_W-1:0] acc [rvc_pkg::NUM_CELLS + 1];

	assign acc[0] = '0;

	rvc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.load_value  (load_value),
		.left_index  (left_index),
		.right_index (right_index),
		.bound_low   (bound_low),
		.bound_high  (bound_high),
		.acc_last    (acc[rvc_pkg::NUM_CELLS]),
		.busy        (busy),
		.done        (done),
		.match_count (match_count),
		.ctl         (ctl),
		.wr          (wr)
	);

	for (genvar gi = 0; gi < rvc_pkg::NUM_CELLS; gi++) begin : g_cell
		rvc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (rvc_pkg::CELL_W'(gi)),
			.ctl     (ctl),
			.wr      (wr),
			.acc_in  (acc[gi]),
			.acc_out (acc[gi + 1])
		);
	end

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == rvc_pkg::KIND_AT_MOST || kind == rvc_pkg::KIND_BAND))
		|=> busy)
		else $error("query accepted but sequencer did not start");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == rvc_pkg::KIND_CLEAR || kind == rvc_pkg::KIND_APPEND))
		|=> (!busy && !done))
		else $error("clear or append occupied the sequencer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> !busy)
		else $error("bank write during a query sweep");
`endif

endmodule

FILE: hw/rtl/rvc_cell.sv
// rvc_cell: one cell of the chain. Owns a bank of stored values, counts hits
// for the broadcast query and adds its count to the running sum from its left.
// Depends on rvc_pkg.
module rvc_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rvc_pkg::CELL_W-1:0]         cell_id,
	input  rvc_pkg::ctl_t                      ctl,
	input  rvc_pkg::wr_t                       wr,
	input  logic signed [rvc_pkg::CNT_W-1:0]   acc_in,
	output logic signed [rvc_pkg::CNT_W-1:0]   acc_out
);

	logic signed [rvc_pkg::VALUE_BITS-1:0] mem [rvc_pkg::BANK_DEPTH];

	logic signed [rvc_pkg::VALUE_BITS-1:0] rd_s1;
	logic [rvc_pkg::BANK_AW-1:0]           addr_s1;
	logic                                  valid_s1;
	logic signed [rvc_pkg::CNT_W-1:0]      cnt_q;
	logic signed [rvc_pkg::CNT_W-1:0]      acc_q;

	logic [rvc_pkg::RNG_W-1:0]             pos;
	logic                                  in_rng;
	logic signed [rvc_pkg::CMP_W-1:0]      v_ext;
	logic signed [rvc_pkg::CMP_W-1:0]      a_ext;
	logic signed [rvc_pkg::CMP_W-1:0]      b_ext;
	logic                                  hit_a;
	logic                                  hit_b;
	logic signed [rvc_pkg::CNT_W-1:0]      delta;

	always_ff @(posedge clk) begin
		if (wr.we && wr.bank == cell_id) begin
			mem[wr.addr] <= wr.data;
		end
		if (ctl.sweep) begin
			rd_s1 <= mem[ctl.addr];
		end
		addr_s1 <= ctl.addr;
	end

	always_comb begin
		pos    = rvc_pkg::RNG_W'({cell_id, addr_s1});
		in_rng = (pos >= ctl.lo) && (pos < ctl.hi);
		v_ext  = rvc_pkg::CMP_W'(rd_s1);
		a_ext  = rvc_pkg::CMP_W'(ctl.bnd_a);
		b_ext  = rvc_pkg::CMP_W'(ctl.bnd_b);
		hit_b  = ctl.incl ? (v_ext <= b_ext) : (v_ext < b_ext);
		hit_a  = ctl.band && (v_ext < a_ext);
		delta  = in_rng ? (rvc_pkg::CNT_W'(hit_b) - rvc_pkg::CNT_W'(hit_a))
		                : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
			acc_q    <= '0;
		end else begin
			valid_s1 <= ctl.sweep;
			if (ctl.clr) begin
				cnt_q <= '0;
			end else if (valid_s1) begin
				cnt_q <= cnt_q + delta;
			end
			// registered hop of the running sum along the chain
			acc_q <= acc_in + cnt_q;
		end
	end

	assign acc_out = acc_q;

endmodule

FILE: hw/rtl/rvc_ctrl.sv
// rvc_ctrl: command sequencer. Tracks the fill level, steers appends into the
// banks, sweeps the bank address for queries and picks up the chain's sum.
// Depends on rvc_pkg.
module rvc_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [1:0]                           kind,
	input  logic signed [rvc_pkg::LOAD_W-1:0]    load_value,
	input  logic [rvc_pkg::IDX_W-1:0]            left_index,
	input  logic [rvc_pkg::IDX_W-1:0]            right_index,
	input  logic signed [rvc_pkg::BOUND_W-1:0]   bound_low,
	input  logic signed [rvc_pkg::BOUND_W-1:0]   bound_high,
	input  logic signed [rvc_pkg::CNT_W-1:0]     acc_last,
	output logic                                 busy,
	output logic                                 done,
	output logic signed [rvc_pkg::CNT_W-1:0]     match_count,
	output rvc_pkg::ctl_t                        ctl,
	output rvc_pkg::wr_t                         wr
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t                               state_q;
	logic [rvc_pkg::FILL_W-1:0]           count_q;
	logic [rvc_pkg::BANK_AW-1:0]          addr_q;
	logic [rvc_pkg::DRAIN_W-1:0]          drain_q;
	logic                                 done_q;
	logic signed [rvc_pkg::CNT_W-1:0]     result_q;
	logic [rvc_pkg::RNG_W-1:0]            lo_q;
	logic [rvc_pkg::RNG_W-1:0]            hi_q;
	logic signed [rvc_pkg::BOUND_W-1:0]   a_q;
	logic signed [rvc_pkg::BOUND_W-1:0]   b_q;
	logic                                 incl_q;
	logic                                 band_q;

	logic                                 accept;
	logic                                 is_query;
	logic                                 not_full;
	logic [rvc_pkg::RNG_W-1:0]            right_ext;
	logic [rvc_pkg::RNG_W-1:0]            fill_ext;
	logic [rvc_pkg::RNG_W-1:0]            hi_clip;

	always_comb begin
		accept    = start && (state_q == ST_IDLE);
		is_query  = kind inside {rvc_pkg::KIND_AT_MOST, rvc_pkg::KIND_BAND};
		not_full  = count_q < rvc_pkg::FILL_W'(rvc_pkg::MAX_ELEMENTS);
		right_ext = rvc_pkg::RNG_W'(right_index);
		fill_ext  = rvc_pkg::RNG_W'(count_q);
		hi_clip   = (right_ext > fill_ext) ? fill_ext : right_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			addr_q   <= '0;
			drain_q  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			a_q      <= '0;
			b_q      <= '0;
			incl_q   <= 1'b0;
			band_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (rvc_pkg::kind_t'(kind))
							rvc_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							rvc_pkg::KIND_APPEND: begin
								if (not_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							rvc_pkg::KIND_AT_MOST, rvc_pkg::KIND_BAND: begin
								lo_q    <= rvc_pkg::RNG_W'(left_index);
								hi_q    <= hi_clip;
								a_q     <= bound_low;
								b_q     <= bound_high;
								incl_q  <= (kind == rvc_pkg::KIND_AT_MOST);
								band_q  <= (kind == rvc_pkg::KIND_BAND);
								addr_q  <= '0;
								state_q <= ST_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SWEEP: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == rvc_pkg::BANK_AW'(rvc_pkg::BANK_DEPTH - 1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					// last count lands in the first drain cycle, then one hop per cell
					if (drain_q == rvc_pkg::DRAIN_W'(rvc_pkg::DRAIN_LEN)) begin
						done_q   <= 1'b1;
						result_q <= acc_last;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl.sweep = (state_q == ST_SWEEP);
		ctl.addr  = addr_q;
		ctl.clr   = accept && is_query;
		ctl.incl  = incl_q;
		ctl.band  = band_q;
		ctl.lo    = lo_q;
		ctl.hi    = hi_q;
		ctl.bnd_a = a_q;
		ctl.bnd_b = b_q;

		wr.we     = accept && (kind == rvc_pkg::KIND_APPEND) && not_full;
		wr.bank   = count_q[rvc_pkg::BANK_AW +: rvc_pkg::CELL_W];
		wr.addr   = count_q[rvc_pkg::BANK_AW-1:0];
		wr.data   = rvc_pkg::VALUE_BITS'(load_value);
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign match_count = result_q;

endmodule

FILE: test/range_value_count_unit_tb.sv
`timescale 1ns / 1ps
// range_value_count_unit_tb: self-checking bench for range_value_count_unit.
// Sends clear, append and query words and checks each count against a shadow array.
// Depends on rvc_pkg and range_value_count_unit.
module range_value_count_unit_tb;
	import rvc_pkg::*;

	localparam int MAX_CYCLES = 1_000_000;
	localparam int QUERY_LAT  = BANK_DEPTH + NUM_CELLS + 3;
	localparam logic signed [BOUND_W-1:0] VAL_MIN = {1'b1, {(BOUND_W-1){1'b0}}};
	localparam logic signed [BOUND_W-1:0] VAL_MAX = {1'b0, {(BOUND_W-1){1'b1}}};

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        start       = 1'b0;
	logic                        busy;
	logic [1:0]                  kind        = KIND_CLEAR;
	logic signed [LOAD_W-1:0]    load_value  = '0;
	logic [IDX_W-1:0]            left_index  = '0;
	logic [IDX_W-1:0]            right_index = '0;
	logic signed [BOUND_W-1:0]   bound_low   = '0;
	logic signed [BOUND_W-1:0]   bound_high  = '0;
	logic                        done;
	logic signed [CNT_W-1:0]     match_count;

	// shadow copy of the loaded array
	logic signed [VALUE_BITS-1:0] shadow_vals [MAX_ELEMENTS];
	int unsigned                  shadow_fill = 0;
	logic signed [CNT_W-1:0]      expected_counts [$];
	logic signed [CNT_W-1:0]      want_count;

	int mismatches      = 0;
	int words_sent      = 0;
	int sender_idle_pct = 0;
	int value_spread    = 16;

	range_value_count_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.load_value  (load_value),
		.left_index  (left_index),
		.right_index (right_index),
		.bound_low   (bound_low),
		.bound_high  (bound_high),
		.done        (done),
		.match_count (match_count)
	);

	always #5 clk = ~clk;

	function automatic logic signed [CNT_W-1:0] predict_count(kind_t k, int unsigned lo,
			int unsigned hi, logic signed [BOUND_W-1:0] a, logic signed [BOUND_W-1:0] b);
		int unsigned end_pos;
		int unsigned i;
		int n;
		end_pos = (hi > shadow_fill) ? shadow_fill : hi;
		n = 0;
		for (i = lo; i < end_pos; i++) begin
			if (k == KIND_AT_MOST) begin
				if (shadow_vals[i] <= b) n++;
			end else begin
				if (shadow_vals[i] < b) n++;
				if (shadow_vals[i] < a) n--;
			end
		end
		return n[CNT_W-1:0];
	endfunction

	function automatic logic signed [LOAD_W-1:0] pick_value(int spread);
		case ($urandom_range(11))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3: return $urandom;
			default: return int'($urandom_range(2 * spread)) - spread;
		endcase
	endfunction

	// bounds land on or next to stored values half the time
	function automatic logic signed [BOUND_W-1:0] pick_bound();
		logic signed [BOUND_W-1:0] v;
		if (shadow_fill > 0 && $urandom_range(1)) begin
			v = shadow_vals[$urandom_range(shadow_fill - 1)];
			return v + int'($urandom_range(2)) - 1;
		end
		return pick_value(value_spread);
	endfunction

	task automatic send_word(kind_t k, logic signed [LOAD_W-1:0] val, logic [IDX_W-1:0] lo,
			logic [IDX_W-1:0] hi, logic signed [BOUND_W-1:0] a,
			logic signed [BOUND_W-1:0] b);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start       <= 1'b1;
		kind        <= k;
		load_value  <= val;
		left_index  <= lo;
		right_index <= hi;
		bound_low   <= a;
		bound_high  <= b;
		do @(posedge clk); while (busy);
		words_sent++;
		case (k)
			KIND_CLEAR: shadow_fill = 0;
			KIND_APPEND: begin
				// a full array drops the word
				if (shadow_fill < MAX_ELEMENTS) begin
					shadow_vals[shadow_fill] = VALUE_BITS'(val);
					shadow_fill++;
				end
			end
			default: expected_counts.push_back(predict_count(k, lo, hi, a, b));
		endcase
	endtask

	task automatic append_value(logic signed [LOAD_W-1:0] v);
		send_word(KIND_APPEND, v, IDX_W'($urandom), IDX_W'($urandom), $urandom, $urandom);
	endtask

	task automatic clear_array();
		send_word(KIND_CLEAR, $urandom, IDX_W'($urandom), IDX_W'($urandom), $urandom,
			$urandom);
	endtask

	task automatic query(kind_t k, int lo, int hi, logic signed [BOUND_W-1:0] a,
			logic signed [BOUND_W-1:0] b);
		send_word(k, $urandom, IDX_W'(lo), IDX_W'(hi), a, b);
	endtask

	task automatic random_query();
		kind_t k;
		int lo;
		int hi;
		k = $urandom_range(1) ? KIND_AT_MOST : KIND_BAND;
		if ($urandom_range(4)) begin
			lo = $urandom_range(shadow_fill);
			hi = $urandom_range(shadow_fill, lo);
		end else begin
			lo = $urandom_range(MAX_ELEMENTS);
			hi = $urandom_range(MAX_ELEMENTS);
		end
		query(k, lo, hi, pick_bound(), pick_bound());
	endtask

	task automatic test_directed_corners();
		sender_idle_pct = 0;
		query(KIND_AT_MOST, 0, MAX_ELEMENTS, $urandom, 0);
		query(KIND_BAND, 0, MAX_ELEMENTS, VAL_MIN, VAL_MAX);
		append_value(VAL_MIN);
		append_value(VAL_MAX);
		append_value(0);
		append_value(-1);
		append_value(1);
		append_value(VAL_MIN);
		append_value(VAL_MAX);
		append_value(5);
		query(KIND_AT_MOST, 0, MAX_ELEMENTS, $urandom, VAL_MIN);
		query(KIND_AT_MOST, 0, 8, $urandom, VAL_MAX);
		query(KIND_AT_MOST, 2, 5, $urandom, 0);
		query(KIND_BAND, 0, 8, -1, 1);
		query(KIND_BAND, 0, 8, 1, -1);         // inverted band
		query(KIND_BAND, 0, 8, 0, 0);
		query(KIND_BAND, 0, 8, VAL_MIN, VAL_MAX);
		query(KIND_AT_MOST, 3, 3, $urandom, VAL_MAX);
		query(KIND_BAND, 6, 2, VAL_MIN, VAL_MAX);
		query(KIND_AT_MOST, MAX_ELEMENTS, MAX_ELEMENTS, $urandom, VAL_MAX);
		query(KIND_AT_MOST, 7, MAX_ELEMENTS, $urandom, VAL_MAX);   // end clipped to fill
		clear_array();
		query(KIND_AT_MOST, 0, MAX_ELEMENTS, $urandom, VAL_MAX);
		append_value(7);
		query(KIND_AT_MOST, 0, 1, $urandom, 7);
	endtask

	task automatic test_full_array();
		sender_idle_pct = 73;
		value_spread = 8;
		clear_array();
		// no VAL_MAX entries, so full-range band counts reach +/-1024
		repeat (MAX_ELEMENTS)
			append_value(($urandom_range(9) == 0) ? VAL_MIN : int'($urandom_range(16)) - 8);
		repeat (3) append_value(VAL_MAX);
		query(KIND_AT_MOST, 0, MAX_ELEMENTS, $urandom, VAL_MAX);
		query(KIND_BAND, 0, MAX_ELEMENTS, VAL_MAX, VAL_MIN);
		query(KIND_BAND, 0, MAX_ELEMENTS, VAL_MIN, VAL_MAX);
		query(KIND_AT_MOST, MAX_ELEMENTS - 1, MAX_ELEMENTS, $urandom, VAL_MIN);
		repeat (6) random_query();
	endtask

	task automatic test_random_sequences(int idle_pct, int n_words);
		int stop_at;
		int len;
		int r;
		sender_idle_pct = idle_pct;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			case ($urandom_range(3))
				0: value_spread = 2;
				1: value_spread = 16;
				2: value_spread = 1000;
				default: value_spread = 100_000_000;
			endcase
			if ($urandom_range(9) == 0) begin
				// noise: any kind, any fields
				repeat ($urandom_range(1, 6))
					send_word(kind_t'($urandom_range(3)), $urandom,
						IDX_W'($urandom_range(MAX_ELEMENTS)),
						IDX_W'($urandom_range(MAX_ELEMENTS)), $urandom, $urandom);
			end else begin
				if ($urandom_range(4)) clear_array();
				r = $urandom_range(99);
				if (r < 75) len = $urandom_range(16);
				else if (r < 97) len = $urandom_range(17, 80);
				else len = $urandom_range(81, 300);
				repeat (len) append_value(pick_value(value_spread));
				repeat ($urandom_range(1, 8)) random_query();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				mismatches++;
				$display("%0t: match_count expected none, got %0d", $time, match_count);
			end else begin
				want_count = expected_counts.pop_front();
				if (match_count !== want_count) begin
					mismatches++;
					$display("%0t: match_count expected %0d, got %0d", $time, want_count,
						match_count);
				end
			end
		end
	end

	initial begin
		repeat (MAX_CYCLES) @(posedge clk);
		$display("range_value_count_unit_tb: done, errors");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_full_array();
		test_random_sequences(0, 300);
		test_random_sequences(73, 300);
		test_random_sequences(18, 300);
		start <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		// watch for stray results
		repeat (QUERY_LAT + 8) @(posedge clk);
		if (mismatches == 0)
			$display("range_value_count_unit_tb: done, clean");
		else
			$display("range_value_count_unit_tb: done, errors");
		$finish;
	end

endmodule
